FILE: rtl/srt_pkg.sv
package srt_pkg;

  // Default largest square side; the message store holds its square.
  localparam int MAX_SIDE_DEF = 64;

  // Stored bytes equal to an asterisk are never returned.
  localparam logic [7:0] SKIP_BYTE = 8'h2A;

  // Operation codes of an input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

endpackage

FILE: rtl/srt_ram.sv
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/square_rotation_transposer.sv
// Square rotation transposer.
// Input channel: an item transfers at a rising edge where start is high and busy is low.
// A push (op = OP_PUSH) stores one message byte while the store has room; the push with
// end_of_message set closes the message. A pull (op = OP_PULL) returns one result on
// the result port, marked by result_strobe for exactly one cycle; the receiver cannot stall it.
// Pulled bytes come from the message padded to an N by N square (N the smallest side whose
// square covers the length), rotated 90 degrees clockwise and read row by row. Padding and
// asterisks are skipped; out_last marks the final byte and out_valid is low when none is left.
// Sequence: a closing push is followed by the side search, which steps through the candidate
// sides, and then by a scan for the first byte. A pull strobes its result after a scan for
// the following byte: a padding position is passed in S_FETCH alone, a stored position is
// read in S_FETCH and checked in S_CHECK. Long runs of asterisks stretch the scan. A result
// strobes in the same cycle in which busy falls, so the next item can transfer then. A pull
// while loading or once the message is exhausted strobes an empty result in the cycle after
// its transfer. busy is high during the search and scans. Reset clears the length and returns
// the block to loading; store contents stay undefined.
module square_rotation_transposer
  import srt_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output out_item_t result,
  output logic      result_strobe
);

  localparam int Capacity = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(Capacity);
  localparam int LEN_W    = $clog2(Capacity + 1);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam logic [LEN_W-1:0]  CAP_LEN  = LEN_W'(Capacity);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SIDE  = 4'b0010,
    S_FETCH = 4'b0100,
    S_CHECK = 4'b1000
  } ctl_state_t;

  typedef enum logic [2:0] {
    PH_LOADING = 3'b001,
    PH_READING = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  ctl_state_t        state, state_next;
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  msg_len, msg_len_next;
  logic [LEN_W-1:0]  side_sq, side_sq_next;
  logic [SIDE_W-1:0] side, side_next;
  logic [SIDE_W-1:0] row, row_next;
  logic [SIDE_W-1:0] col, col_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [ADDR_W-1:0] top, top_next;
  logic [7:0]        head_byte, head_byte_next;
  logic              pending_pull, pending_pull_next;
  out_item_t         result_next;
  logic              result_strobe_next;

  logic              wr_en, rd_en;
  logic [7:0]        rd_data;
  logic [LEN_W-1:0]  base_len;
  logic [SIDE_W-1:0] row_inc;
  logic              last_col, at_end, pos_in_msg;
  logic [SIDE_W-1:0] row_adv, col_adv;
  logic [ADDR_W-1:0] pos_adv;

  srt_ram #(
    .WIDTH (8),
    .DEPTH (Capacity)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base_len[ADDR_W-1:0]),
    .wr_data (item.in_byte),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  assign busy = (state != S_IDLE);

  // A push after a closed message starts a new one from the beginning.
  assign base_len = (phase == PH_LOADING) ? msg_len : '0;

  // Cursor stepping. Along a row the source index drops by N; a new row
  // restarts at the bottom row of the unrotated square, offset by the row.
  assign row_inc    = row + SIDE_W'(1);
  assign last_col   = (col + SIDE_W'(1)) == side;
  assign at_end     = (row == side);
  assign pos_in_msg = LEN_W'(pos) < msg_len;

  always_comb begin
    if (last_col) begin
      row_adv = row_inc;
      col_adv = '0;
      pos_adv = top + ADDR_W'(row_inc);
    end else begin
      row_adv = row;
      col_adv = col + SIDE_W'(1);
      pos_adv = pos - ADDR_W'(side);
    end
  end

  // Control sequencer.
  always_comb begin
    state_next         = state;
    phase_next         = phase;
    msg_len_next       = msg_len;
    side_sq_next       = side_sq;
    side_next          = side;
    row_next           = row;
    col_next           = col;
    pos_next           = pos;
    top_next           = top;
    head_byte_next     = head_byte;
    pending_pull_next  = pending_pull;
    result_next        = result;
    result_strobe_next = 1'b0;
    wr_en              = 1'b0;
    rd_en              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (item.op == OP_PUSH) begin
            phase_next = PH_LOADING;
            if (base_len < CAP_LEN) begin
              wr_en        = 1'b1;
              msg_len_next = base_len + LEN_W'(1);
            end else begin
              msg_len_next = base_len;
            end
            if (item.end_of_message) begin
              side_next    = '0;
              side_sq_next = '0;
              state_next   = S_SIDE;
            end
          end else if (phase == PH_READING) begin
            pending_pull_next = 1'b1;
            state_next        = S_FETCH;
          end else begin
            result_next        = '0;
            result_strobe_next = 1'b1;
          end
        end
      end

      // Smallest side whose square covers the length; the square grows by 2N+1.
      S_SIDE: begin
        if ((side < SIDE_MAX) && (side_sq < msg_len)) begin
          side_sq_next = side_sq + LEN_W'({side, 1'b1});
          side_next    = side + SIDE_W'(1);
        end else begin
          top_next          = ADDR_W'(side_sq - LEN_W'(side));
          pos_next          = ADDR_W'(side_sq - LEN_W'(side));
          row_next          = '0;
          col_next          = '0;
          pending_pull_next = 1'b0;
          state_next        = S_FETCH;
        end
      end

      // Walk the cursor; padding positions are passed without a read.
      S_FETCH: begin
        if (at_end) begin
          phase_next = PH_DONE;
          if (pending_pull) begin
            result_next.out_byte  = head_byte;
            result_next.out_valid = 1'b1;
            result_next.out_last  = 1'b1;
            result_strobe_next    = 1'b1;
          end
          state_next = S_IDLE;
        end else begin
          row_next = row_adv;
          col_next = col_adv;
          pos_next = pos_adv;
          if (pos_in_msg) begin
            rd_en      = 1'b1;
            state_next = S_CHECK;
          end
        end
      end

      // A stored byte that is not an asterisk becomes the new head.
      S_CHECK: begin
        if (rd_data != SKIP_BYTE) begin
          if (pending_pull) begin
            result_next.out_byte  = head_byte;
            result_next.out_valid = 1'b1;
            result_next.out_last  = 1'b0;
            result_strobe_next    = 1'b1;
          end
          head_byte_next = rd_data;
          phase_next     = PH_READING;
          state_next     = S_IDLE;
        end else begin
          state_next = S_FETCH;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_LOADING;
      msg_len       <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      msg_len       <= msg_len_next;
      result_strobe <= result_strobe_next;
    end
    side_sq      <= side_sq_next;
    side         <= side_next;
    row          <= row_next;
    col          <= col_next;
    pos          <= pos_next;
    top          <= top_next;
    head_byte    <= head_byte_next;
    pending_pull <= pending_pull_next;
    result       <= result_next;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import srt_pkg::*;

  localparam int unsigned CAPACITY = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned TARGET_ITEMS = 1400;

  // Tracks the message the block holds and the bytes that its pulls must return.
  class rotated_byte_tracker;
    typedef enum {LOADING, READING, DONE} msg_phase_t;

    logic [7:0] store [CAPACITY];
    int unsigned msg_len = 0;
    int unsigned side = 0;
    int unsigned row = 0;
    int unsigned col = 0;
    msg_phase_t phase = LOADING;
    out_item_t due_bytes [$];
    int unsigned n_mismatch = 0;

    // Message index shown at rotated position t, or CAPACITY for padding and asterisks.
    function int unsigned source_index(int unsigned t);
      int unsigned r, c, p;
      if (side == 0) begin
        return CAPACITY;
      end
      r = t / side;
      c = t % side;
      p = side * (side - 1 - c) + r;
      if (p >= msg_len || store[p] == SKIP_BYTE) begin
        return CAPACITY;
      end
      return p;
    endfunction

    // First rotated position at or after t that yields a byte.
    function int unsigned next_position(int unsigned t);
      while (t < side * side && source_index(t) == CAPACITY) begin
        t++;
      end
      return t;
    endfunction

    // Updates the message state for an accepted item and queues the byte a pull returns.
    function void note_transfer(in_item_t it);
      out_item_t want;
      int unsigned t, after;
      if (it.op == OP_PUSH) begin
        if (phase != LOADING) begin
          msg_len = 0;
          phase = LOADING;
        end
        if (msg_len < CAPACITY) begin
          store[msg_len] = it.in_byte;
          msg_len++;
        end
        // Closing: the side is the smallest one whose square covers the length.
        if (it.end_of_message) begin
          side = 0;
          while (side < MAX_SIDE_DEF && side * side < msg_len) begin
            side++;
          end
          row = 0;
          col = 0;
          phase = READING;
        end
      end else begin
        want = '0;
        if (phase == READING) begin
          t = next_position(row * side + col);
          if (t >= side * side) begin
            phase = DONE;
          end else begin
            after = next_position(t + 1);
            want.out_byte = store[source_index(t)];
            want.out_valid = 1'b1;
            if (after >= side * side) begin
              want.out_last = 1'b1;
              phase = DONE;
              row = side;
              col = 0;
            end else begin
              row = after / side;
              col = after % side;
            end
          end
        end
        due_bytes.push_back(want);
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      n_mismatch++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endfunction

    // Compares one strobed result with the oldest pull still waiting.
    function void check_byte(out_item_t got);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        n_mismatch++;
        $display("%0t: result with no pull waiting, expected none, actual %03h",
                 $time, got);
      end else begin
        want = due_bytes.pop_front();
        if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
        if (got.out_valid !== want.out_valid) begin
          report("out_valid", 8'(want.out_valid), 8'(got.out_valid));
        end
        if (got.out_last !== want.out_last) begin
          report("out_last", 8'(want.out_last), 8'(got.out_last));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t item = '0;
  logic busy;
  out_item_t result;
  logic result_strobe;

  rotated_byte_tracker tracker = new();
  int unsigned idle_pct = 0;
  int unsigned sent_items = 0;
  int unsigned quiet_cycles = 0;

  square_rotation_transposer i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result(result),
    .result_strobe(result_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results are checked before the item accepted at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) tracker.check_byte(result);
      if (start && !busy) tracker.note_transfer(item);
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer and no result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item after a random idle gap and holds it until the transfer.
  task automatic transfer_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  task automatic push_byte(logic [7:0] b, logic eom);
    in_item_t it;
    it.op = OP_PUSH;
    it.in_byte = b;
    it.end_of_message = eom;
    transfer_item(it);
  endtask

  // Pulls carry random filler in the unused fields.
  task automatic pull_byte();
    in_item_t it;
    it.op = OP_PULL;
    it.in_byte = 8'($urandom);
    it.end_of_message = 1'($urandom);
    transfer_item(it);
  endtask

  // Loads one message, then pulls it out in full, past its end, or only partly.
  task automatic send_message(int unsigned len, int unsigned star_pct, bit cut_short);
    int unsigned kept, pulls;
    logic [7:0] b;
    kept = 0;
    for (int unsigned i = 0; i < len; i++) begin
      b = ($urandom_range(99) < star_pct) ? SKIP_BYTE : 8'($urandom);
      if (b != SKIP_BYTE && i < CAPACITY) kept++;
      // Occasional pull in the middle of loading.
      if ($urandom_range(99) < 4) pull_byte();
      push_byte(b, i == len - 1);
    end
    if (cut_short && kept > 1) begin
      pulls = $urandom_range(kept - 1);
    end else begin
      pulls = kept + $urandom_range(2);
    end
    repeat (pulls) pull_byte();
  endtask

  initial begin
    int unsigned len, sel, k, star_pct;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: pull while loading, extreme bytes, padding and an asterisk.
    pull_byte();
    push_byte(8'h00, 1'b0);
    pull_byte();
    push_byte(8'hFF, 1'b0);
    push_byte(SKIP_BYTE, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);
    repeat (6) pull_byte();
    // A one-byte message pushed after the previous one is done.
    push_byte(8'h41, 1'b1);
    repeat (2) pull_byte();
    // A message of asterisks only is exhausted at once.
    push_byte(SKIP_BYTE, 1'b0);
    push_byte(SKIP_BYTE, 1'b1);
    pull_byte();
    // A push while reading starts a new message.
    for (int i = 1; i <= 4; i++) push_byte(8'(i), i == 4);
    pull_byte();
    push_byte(8'hAA, 1'b1);
    pull_byte();

    // Random messages, with the sender idling differently from phase to phase.
    for (int unsigned m = 0; sent_items < TARGET_ITEMS; m++) begin
      case ((m / 4) % 4)
        0: idle_pct = 0;
        1: idle_pct = 62;
        2: idle_pct = 0;
        default: idle_pct = 16;
      endcase
      sel = $urandom_range(99);
      if (sel < 20) begin
        k = $urandom_range(1, 12);
        len = k * k + $urandom_range(1);
      end else if (sel < 65) begin
        len = $urandom_range(1, 16);
      end else if (sel < 93) begin
        len = $urandom_range(17, 80);
      end else begin
        len = $urandom_range(81, 400);
      end
      sel = $urandom_range(9);
      star_pct = (sel < 5) ? 0 : (sel < 8) ? 12 : (sel < 9) ? 85 : 100;
      send_message(len, star_pct, $urandom_range(9) == 0);
    end

    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.n_mismatch == 0 && tracker.due_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
